// ===== design/gcode_pkg.sv =====
// ----------------------------------------------------------------------------
// G-code line parser package
// Token kinds, character and command codes, register indexes and the
// letter decoder shared by the line parser.
// ----------------------------------------------------------------------------
package gcode_pkg;

   localparam int LINE_BUFFER_BYTES = 128;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 32;
   localparam int SPU_W   = 16;
   localparam int FEED_W  = 16;
   localparam int CMD_W   = 8;
   localparam int AXES    = 4;
   localparam int CSR_W   = 2;

   typedef enum logic [2:0] {
      TOK_NONE = 3'd0,
      TOK_G    = 3'd1,
      TOK_M    = 3'd2,
      TOK_X    = 3'd3,
      TOK_Y    = 3'd4,
      TOK_Z    = 3'd5,
      TOK_F    = 3'd6,
      TOK_SKIP = 3'd7
   } token_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_SPU_X = 2'd0,
      CSR_SPU_Y = 2'd1,
      CSR_SPU_Z = 2'd2,
      CSR_SPARE = 2'd3
   } csr_index_type;

   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'd43;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'd70;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_G = 8'd71;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_M = 8'd77;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'd88;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Y = 8'd89;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;

   localparam logic [CMD_W-1:0] CMD_G0      = 8'd0;
   localparam logic [CMD_W-1:0] CMD_G1      = 8'd1;
   localparam logic [CMD_W-1:0] CMD_G21     = 8'd21;
   localparam logic [CMD_W-1:0] CMD_G28     = 8'd28;
   localparam logic [CMD_W-1:0] CMD_G90     = 8'd90;
   localparam logic [CMD_W-1:0] CMD_M30     = 8'd30;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 8'd255;

   localparam int PRESENT_X = 0;
   localparam int PRESENT_Y = 1;
   localparam int PRESENT_Z = 2;
   localparam int PRESENT_F = 3;

   localparam logic [VALUE_W-1:0]   VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0]   VALUE_MIN = 32'h8000_0000;
   localparam logic [VALUE_W+3:0]   MAG_LIMIT = 36'h0_8000_0000;

   function automatic token_type letter_kind(input logic [CHAR_W-1:0] c);
      token_type kind;
      unique case (c)
         CHAR_UPPER_G: kind = TOK_G;
         CHAR_UPPER_M: kind = TOK_M;
         CHAR_UPPER_X: kind = TOK_X;
         CHAR_UPPER_Y: kind = TOK_Y;
         CHAR_UPPER_Z: kind = TOK_Z;
         CHAR_UPPER_F: kind = TOK_F;
         default:      kind = TOK_SKIP;
      endcase
      return kind;
   endfunction

endpackage

// ===== design/gcode_line_to_step_command.sv =====
// ----------------------------------------------------------------------------
// G-code line to step command
// Parses one line of G-code text a byte at a time and emits one step command
// for every newline.
// ----------------------------------------------------------------------------
// Bytes arrive on the req channel, one transfer per byte, and one can be taken
// in every cycle while a pipeline stage is free. A newline byte produces one
// transfer on the rsp channel with the command code, the presence mask, the
// scaled X, Y and Z steps and the feed. Once the newline is taken, the result
// passes through the register stages: the first holds the finished line, the
// second holds the result after the steps-per-unit multipliers and saturation.
// Other bytes produce no result. Bytes after the first LINE_BUFFER_BYTES-1 of a
// line, and bytes after a NUL, are dropped until the newline.
// The csr channel is always ready and writes the three steps-per-unit
// registers; a write to the spare index is taken and ignored.
// Reset clears the line state and the pipeline and sets every steps-per-unit
// register to one. When the rsp side stalls, the finished line waits in the
// first stage and req_ready falls only while both stages are full; bytes of
// the next line keep flowing as long as a stage is free.
// ----------------------------------------------------------------------------
module gcode_line_to_step_command #(
   parameter int LINE_BUFFER_BYTES = gcode_pkg::LINE_BUFFER_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gcode_pkg::CHAR_W-1:0]        req_line_char,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gcode_pkg::CMD_W-1:0]         rsp_command_code,
   output logic [gcode_pkg::AXES-1:0]          rsp_axis_present,
   output logic signed [gcode_pkg::VALUE_W-1:0] rsp_x_steps,
   output logic signed [gcode_pkg::VALUE_W-1:0] rsp_y_steps,
   output logic signed [gcode_pkg::VALUE_W-1:0] rsp_z_steps,
   output logic [gcode_pkg::FEED_W-1:0]        rsp_feed_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gcode_pkg::CSR_W-1:0]         csr_index,
   input  logic [gcode_pkg::SPU_W-1:0]         csr_data
);

   localparam int POS_W = (LINE_BUFFER_BYTES > 1) ? $clog2(LINE_BUFFER_BYTES) : 1;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_BUFFER_BYTES - 1);
   localparam int VW = gcode_pkg::VALUE_W;
   localparam int PW = gcode_pkg::VALUE_W + gcode_pkg::SPU_W + 1;

   logic [gcode_pkg::SPU_W-1:0] spu_ff [0:2];

   gcode_pkg::token_type letter_ff, letter_in;
   logic             negative_ff, negative_in;
   logic             ended_ff, ended_in;
   logic             started_ff, started_in;
   logic [VW-1:0]    acc_ff, acc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             cut_ff, cut_in;
   logic [VW-1:0]    axis_ff [0:gcode_pkg::AXES-1];
   logic [VW-1:0]    axis_in [0:gcode_pkg::AXES-1];
   logic [gcode_pkg::AXES-1:0]  presence_ff, presence_in;
   logic [gcode_pkg::CMD_W-1:0] command_ff, command_in;

   logic [VW-1:0]               fin_axis [0:gcode_pkg::AXES-1];
   logic [gcode_pkg::AXES-1:0]  fin_presence;
   logic [gcode_pkg::CMD_W-1:0] fin_command;
   logic [VW-1:0]               token_value;
   logic [VW+3:0]               acc_wide;
   logic [VW+3:0]               acc_next;

   logic                        s1_valid_ff, s1_valid_in;
   logic [gcode_pkg::CMD_W-1:0] s1_command_ff;
   logic [gcode_pkg::AXES-1:0]  s1_presence_ff;
   logic [VW-1:0]               s1_axis_ff [0:gcode_pkg::AXES-1];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gcode_pkg::CMD_W-1:0] rsp_command_ff;
   logic [gcode_pkg::AXES-1:0]  rsp_presence_ff;
   logic [VW-1:0]               rsp_steps_ff [0:2];
   logic [VW-1:0]               steps_in [0:2];
   logic [gcode_pkg::FEED_W-1:0] rsp_feed_ff, feed_in;

   logic out_take;
   logic s1_move;
   logic accept;
   logic accept_newline;

   assign out_take       = !rsp_valid_ff || rsp_ready;
   assign s1_move        = s1_valid_ff && out_take;
   assign req_ready      = !s1_valid_ff || out_take;
   assign accept         = req_valid && req_ready;
   assign accept_newline = accept && (req_line_char == gcode_pkg::CHAR_NEWLINE);
   assign csr_ready      = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spu_ff[0] <= gcode_pkg::SPU_W'(1);
         spu_ff[1] <= gcode_pkg::SPU_W'(1);
         spu_ff[2] <= gcode_pkg::SPU_W'(1);
      end else if (csr_valid) begin
         unique case (gcode_pkg::csr_index_type'(csr_index))
            gcode_pkg::CSR_SPU_X: spu_ff[0] <= csr_data;
            gcode_pkg::CSR_SPU_Y: spu_ff[1] <= csr_data;
            gcode_pkg::CSR_SPU_Z: spu_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Value of the token in progress and the line state once it is closed.
   always_comb begin
      if (negative_ff) begin
         token_value = ~acc_ff + VW'(1);
      end else if (acc_ff[VW-1]) begin
         token_value = gcode_pkg::VALUE_MAX;
      end else begin
         token_value = acc_ff;
      end
      fin_command  = command_ff;
      fin_presence = presence_ff;
      for (int i = 0; i < gcode_pkg::AXES; i++) begin
         fin_axis[i] = axis_ff[i];
      end
      unique case (letter_ff)
         gcode_pkg::TOK_G: begin
            if (token_value == VW'(gcode_pkg::CMD_G0)  || token_value == VW'(gcode_pkg::CMD_G1) ||
                token_value == VW'(gcode_pkg::CMD_G21) || token_value == VW'(gcode_pkg::CMD_G28) ||
                token_value == VW'(gcode_pkg::CMD_G90)) begin
               fin_command = token_value[gcode_pkg::CMD_W-1:0];
            end else begin
               fin_command = gcode_pkg::CMD_UNKNOWN;
            end
         end
         gcode_pkg::TOK_M: begin
            if (token_value == VW'(gcode_pkg::CMD_M30)) begin
               fin_command = gcode_pkg::CMD_M30;
            end
         end
         gcode_pkg::TOK_X: begin
            fin_axis[gcode_pkg::PRESENT_X]     = token_value;
            fin_presence[gcode_pkg::PRESENT_X] = 1'b1;
         end
         gcode_pkg::TOK_Y: begin
            fin_axis[gcode_pkg::PRESENT_Y]     = token_value;
            fin_presence[gcode_pkg::PRESENT_Y] = 1'b1;
         end
         gcode_pkg::TOK_Z: begin
            fin_axis[gcode_pkg::PRESENT_Z]     = token_value;
            fin_presence[gcode_pkg::PRESENT_Z] = 1'b1;
         end
         gcode_pkg::TOK_F: begin
            fin_axis[gcode_pkg::PRESENT_F]     = token_value;
            fin_presence[gcode_pkg::PRESENT_F] = 1'b1;
         end
         default: ;
      endcase
   end

   assign acc_wide = {4'b0, acc_ff};

   always_comb begin
      acc_next = (acc_wide << 3) + (acc_wide << 1) +
                 (VW+4)'(req_line_char - gcode_pkg::CHAR_ZERO);
      if (acc_next > gcode_pkg::MAG_LIMIT) begin
         acc_next = gcode_pkg::MAG_LIMIT;
      end
   end

   always_comb begin
      letter_in   = letter_ff;
      negative_in = negative_ff;
      ended_in    = ended_ff;
      started_in  = started_ff;
      acc_in      = acc_ff;
      pos_in      = pos_ff;
      cut_in      = cut_ff;
      presence_in = presence_ff;
      command_in  = command_ff;
      for (int i = 0; i < gcode_pkg::AXES; i++) begin
         axis_in[i] = axis_ff[i];
      end
      if (accept_newline) begin
         letter_in   = gcode_pkg::TOK_NONE;
         negative_in = 1'b0;
         ended_in    = 1'b0;
         started_in  = 1'b0;
         acc_in      = '0;
         pos_in      = '0;
         cut_in      = 1'b0;
         presence_in = '0;
         command_in  = '0;
         for (int i = 0; i < gcode_pkg::AXES; i++) begin
            axis_in[i] = '0;
         end
      end else if (accept && !cut_ff && pos_ff < POS_LIMIT) begin
         pos_in = pos_ff + POS_W'(1);
         priority if (req_line_char == gcode_pkg::CHAR_NUL) begin
            cut_in = 1'b1;
         end else if (req_line_char == gcode_pkg::CHAR_SPACE ||
                      req_line_char == gcode_pkg::CHAR_TAB) begin
            command_in  = fin_command;
            presence_in = fin_presence;
            for (int i = 0; i < gcode_pkg::AXES; i++) begin
               axis_in[i] = fin_axis[i];
            end
            letter_in   = gcode_pkg::TOK_NONE;
            negative_in = 1'b0;
            ended_in    = 1'b0;
            started_in  = 1'b0;
            acc_in      = '0;
         end else if (letter_ff == gcode_pkg::TOK_NONE) begin
            letter_in = gcode_pkg::letter_kind(req_line_char);
         end else if (letter_ff == gcode_pkg::TOK_SKIP || ended_ff) begin
         end else if (!started_ff && (req_line_char == gcode_pkg::CHAR_PLUS ||
                                      req_line_char == gcode_pkg::CHAR_MINUS)) begin
            started_in  = 1'b1;
            negative_in = (req_line_char == gcode_pkg::CHAR_MINUS);
         end else if (req_line_char >= gcode_pkg::CHAR_ZERO &&
                      req_line_char <= gcode_pkg::CHAR_NINE) begin
            acc_in     = acc_next[VW-1:0];
            started_in = 1'b1;
         end else begin
            ended_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_ff   <= gcode_pkg::TOK_NONE;
         negative_ff <= 1'b0;
         ended_ff    <= 1'b0;
         started_ff  <= 1'b0;
         acc_ff      <= '0;
         pos_ff      <= '0;
         cut_ff      <= 1'b0;
         presence_ff <= '0;
         command_ff  <= '0;
         for (int i = 0; i < gcode_pkg::AXES; i++) begin
            axis_ff[i] <= '0;
         end
      end else begin
         letter_ff   <= letter_in;
         negative_ff <= negative_in;
         ended_ff    <= ended_in;
         started_ff  <= started_in;
         acc_ff      <= acc_in;
         pos_ff      <= pos_in;
         cut_ff      <= cut_in;
         presence_ff <= presence_in;
         command_ff  <= command_in;
         for (int i = 0; i < gcode_pkg::AXES; i++) begin
            axis_ff[i] <= axis_in[i];
         end
      end
   end

   assign s1_valid_in  = accept_newline ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_newline) begin
         s1_command_ff  <= fin_command;
         s1_presence_ff <= fin_presence;
         for (int i = 0; i < gcode_pkg::AXES; i++) begin
            s1_axis_ff[i] <= fin_axis[i];
         end
      end
   end

   // Scale each axis by its steps-per-unit and clamp to the signed range.
   always_comb begin
      logic signed [PW-1:0] product;
      for (int i = 0; i < 3; i++) begin
         product = $signed(s1_axis_ff[i]) * $signed({1'b0, spu_ff[i]});
         if (!s1_presence_ff[i]) begin
            steps_in[i] = '0;
         end else if (product > $signed(PW'($signed(gcode_pkg::VALUE_MAX)))) begin
            steps_in[i] = gcode_pkg::VALUE_MAX;
         end else if (product < $signed({{(PW-VW){1'b1}}, gcode_pkg::VALUE_MIN})) begin
            steps_in[i] = gcode_pkg::VALUE_MIN;
         end else begin
            steps_in[i] = product[VW-1:0];
         end
      end
      feed_in = s1_presence_ff[gcode_pkg::PRESENT_F] ?
                s1_axis_ff[gcode_pkg::PRESENT_F][gcode_pkg::FEED_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_command_ff  <= s1_command_ff;
         rsp_presence_ff <= s1_presence_ff;
         for (int i = 0; i < 3; i++) begin
            rsp_steps_ff[i] <= steps_in[i];
         end
         rsp_feed_ff <= feed_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_code = rsp_command_ff;
   assign rsp_axis_present = rsp_presence_ff;
   assign rsp_x_steps      = $signed(rsp_steps_ff[0]);
   assign rsp_y_steps      = $signed(rsp_steps_ff[1]);
   assign rsp_z_steps      = $signed(rsp_steps_ff[2]);
   assign rsp_feed_value   = rsp_feed_ff;

endmodule

// ===== test/gcode_step_checker.sv =====
// ----------------------------------------------------------------------------
// G-code step command checker
// Watches the byte, result and register channels of the line parser. Every
// byte transfer runs through a local line parser that builds the expected
// step command on each newline; every result transfer is compared with the
// oldest expected command. Failures and outstanding commands are reported
// to the testbench top.
// ----------------------------------------------------------------------------
module gcode_step_checker
   import gcode_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [CHAR_W-1:0]          req_line_char,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [CMD_W-1:0]           rsp_command_code,
   input  logic [AXES-1:0]            rsp_axis_present,
   input  logic signed [VALUE_W-1:0]  rsp_x_steps,
   input  logic signed [VALUE_W-1:0]  rsp_y_steps,
   input  logic signed [VALUE_W-1:0]  rsp_z_steps,
   input  logic [FEED_W-1:0]          rsp_feed_value,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_W-1:0]           csr_index,
   input  logic [SPU_W-1:0]           csr_data,
   output int                         error_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint MAG_CAP  = 64'sd2147483648;
   localparam longint STEP_MAX = 64'sd2147483647;
   localparam longint STEP_MIN = -64'sd2147483648;
   localparam int     REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CMD_W-1:0]          command_code;
      logic [AXES-1:0]           axis_present;
      logic signed [VALUE_W-1:0] x_steps;
      logic signed [VALUE_W-1:0] y_steps;
      logic signed [VALUE_W-1:0] z_steps;
      logic [FEED_W-1:0]         feed_value;
   } step_cmd_t;

   step_cmd_t        expected_cmds[$];
   logic [SPU_W-1:0] steps_per_unit [3];

   token_type        word_kind;
   bit               word_negative;
   bit               word_done;
   bit               word_started;
   longint           word_magnitude;
   int               line_column;
   bit               line_dropped;
   longint           axis_word [AXES];
   logic [AXES-1:0]  axis_seen;
   logic [CMD_W-1:0] cmd_word;
   int               failures = 0;

   function automatic token_type word_letter(input logic [CHAR_W-1:0] c);
      case (c)
         CHAR_UPPER_G: return TOK_G;
         CHAR_UPPER_M: return TOK_M;
         CHAR_UPPER_X: return TOK_X;
         CHAR_UPPER_Y: return TOK_Y;
         CHAR_UPPER_Z: return TOK_Z;
         CHAR_UPPER_F: return TOK_F;
         default:      return TOK_SKIP;
      endcase
   endfunction

   function automatic void clear_word();
      word_kind      = TOK_NONE;
      word_negative  = 1'b0;
      word_done      = 1'b0;
      word_started   = 1'b0;
      word_magnitude = 0;
   endfunction

   function automatic void clear_line();
      clear_word();
      line_column  = 0;
      line_dropped = 1'b0;
      foreach (axis_word[i]) axis_word[i] = 0;
      axis_seen = '0;
      cmd_word  = CMD_G0;
   endfunction

   function automatic longint word_value();
      if (word_negative) return -word_magnitude;
      return (word_magnitude >= MAG_CAP) ? MAG_CAP - 1 : word_magnitude;
   endfunction

   function automatic void close_word();
      longint v;
      v = word_value();
      case (word_kind)
         TOK_G: begin
            if (v == CMD_G0 || v == CMD_G1 || v == CMD_G21 || v == CMD_G28 || v == CMD_G90)
               cmd_word = v[CMD_W-1:0];
            else
               cmd_word = CMD_UNKNOWN;
         end
         TOK_M: begin
            if (v == CMD_M30) cmd_word = CMD_M30;
         end
         TOK_X: begin
            axis_word[PRESENT_X] = v;
            axis_seen[PRESENT_X] = 1'b1;
         end
         TOK_Y: begin
            axis_word[PRESENT_Y] = v;
            axis_seen[PRESENT_Y] = 1'b1;
         end
         TOK_Z: begin
            axis_word[PRESENT_Z] = v;
            axis_seen[PRESENT_Z] = 1'b1;
         end
         TOK_F: begin
            axis_word[PRESENT_F] = v;
            axis_seen[PRESENT_F] = 1'b1;
         end
         default: begin
         end
      endcase
      clear_word();
   endfunction

   function automatic logic signed [VALUE_W-1:0] scale_axis(input longint v,
                                                           input logic [SPU_W-1:0] k);
      longint p;
      p = v * longint'(k);
      if (p > STEP_MAX) p = STEP_MAX;
      if (p < STEP_MIN) p = STEP_MIN;
      return p[VALUE_W-1:0];
   endfunction

   function automatic void take_char(input logic [CHAR_W-1:0] c);
      step_cmd_t cmd;
      longint    m;
      if (c == CHAR_NEWLINE) begin
         close_word();
         cmd.command_code = cmd_word;
         cmd.axis_present = axis_seen;
         cmd.x_steps = axis_seen[PRESENT_X] ?
                       scale_axis(axis_word[PRESENT_X], steps_per_unit[CSR_SPU_X]) : '0;
         cmd.y_steps = axis_seen[PRESENT_Y] ?
                       scale_axis(axis_word[PRESENT_Y], steps_per_unit[CSR_SPU_Y]) : '0;
         cmd.z_steps = axis_seen[PRESENT_Z] ?
                       scale_axis(axis_word[PRESENT_Z], steps_per_unit[CSR_SPU_Z]) : '0;
         cmd.feed_value = axis_seen[PRESENT_F] ? axis_word[PRESENT_F][FEED_W-1:0] : '0;
         expected_cmds.push_back(cmd);
         clear_line();
      end else if (!line_dropped && line_column < LINE_BUFFER_BYTES - 1) begin
         line_column++;
         if (c == CHAR_NUL) begin
            line_dropped = 1'b1;
         end else if (c == CHAR_SPACE || c == CHAR_TAB) begin
            close_word();
         end else if (word_kind == TOK_NONE) begin
            word_kind = word_letter(c);
         end else if (word_kind != TOK_SKIP && !word_done) begin
            if (!word_started && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
               word_started  = 1'b1;
               word_negative = (c == CHAR_MINUS);
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               m = word_magnitude * 10 + longint'(c - CHAR_ZERO);
               word_magnitude = (m > MAG_CAP) ? MAG_CAP : m;
               word_started   = 1'b1;
            end else begin
               word_done = 1'b1;
            end
         end
      end
   endfunction

   always @(posedge clock) begin : monitor
      step_cmd_t got;
      step_cmd_t want;
      if (reset) begin
         expected_cmds.delete();
         foreach (steps_per_unit[i]) steps_per_unit[i] = 1;
         clear_line();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.command_code = rsp_command_code;
            got.axis_present = rsp_axis_present;
            got.x_steps      = rsp_x_steps;
            got.y_steps      = rsp_y_steps;
            got.z_steps      = rsp_z_steps;
            got.feed_value   = rsp_feed_value;
            if (expected_cmds.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("unexpected step command transfer: cmd=%0d mask=%b",
                           got.command_code, got.axis_present);
            end else begin
               want = expected_cmds.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display({"step command mismatch: expected cmd=%0d mask=%b x=%0d y=%0d",
                               " z=%0d feed=%0d, got cmd=%0d mask=%b x=%0d y=%0d z=%0d",
                               " feed=%0d"},
                              want.command_code, want.axis_present, want.x_steps,
                              want.y_steps, want.z_steps, want.feed_value,
                              got.command_code, got.axis_present, got.x_steps,
                              got.y_steps, got.z_steps, got.feed_value);
               end
            end
         end
         if (csr_valid && csr_ready && csr_index != CSR_SPARE)
            steps_per_unit[csr_index] = csr_data;
         if (req_valid && req_ready)
            take_char(req_line_char);
      end
      pending_count <= expected_cmds.size();
      error_count   <= failures;
   end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// G-code line to step command testbench
// Feeds directed and random G-code lines into the parser byte by byte, with
// random gaps on the byte and result channels and one long result stall,
// changes the steps-per-unit registers between phases, and reports the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gcode_pkg::*;

   localparam int  RESET_CYCLES      = 6;
   localparam int  SETTLE_CYCLES     = 10;
   localparam int  LONG_STALL_CYCLES = 150;
   localparam int  PHASE_CHARS       = 120;
   localparam real TIMEOUT_NS        = 2_000_000.0;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [CHAR_W-1:0]         req_line_char = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [CMD_W-1:0]          rsp_command_code;
   logic [AXES-1:0]           rsp_axis_present;
   logic signed [VALUE_W-1:0] rsp_x_steps;
   logic signed [VALUE_W-1:0] rsp_y_steps;
   logic signed [VALUE_W-1:0] rsp_z_steps;
   logic [FEED_W-1:0]         rsp_feed_value;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_W-1:0]          csr_index = '0;
   logic [SPU_W-1:0]          csr_data = '0;

   int                error_count;
   int                pending_count;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   bit                long_stall_req = 1'b0;
   int                stall_cycles = 0;
   int                chars_sent = 0;
   logic [CHAR_W-1:0] line_bytes[$];
   int                known_g [5] = '{CMD_G0, CMD_G1, CMD_G21, CMD_G28, CMD_G90};

   gcode_line_to_step_command u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_line_char    (req_line_char),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_code (rsp_command_code),
      .rsp_axis_present (rsp_axis_present),
      .rsp_x_steps      (rsp_x_steps),
      .rsp_y_steps      (rsp_y_steps),
      .rsp_z_steps      (rsp_z_steps),
      .rsp_feed_value   (rsp_feed_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   gcode_step_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_line_char    (req_line_char),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_code (rsp_command_code),
      .rsp_axis_present (rsp_axis_present),
      .rsp_x_steps      (rsp_x_steps),
      .rsp_y_steps      (rsp_y_steps),
      .rsp_z_steps      (rsp_z_steps),
      .rsp_feed_value   (rsp_feed_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (long_stall_req && stall_cycles < LONG_STALL_CYCLES) begin
         rsp_ready    <= 1'b0;
         stall_cycles <= stall_cycles + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [CHAR_W-1:0] c);
      req_line_char <= c;
      req_valid     <= 1'b1;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
      send_byte(CHAR_NEWLINE);
      line_bytes.delete();
   endtask

   task automatic send_text(input string s);
      push_text(s);
      send_line();
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [SPU_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_lines();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_digits();
      int n;
      case ($urandom_range(3))
         0: line_bytes.push_back(CHAR_PLUS);
         1: line_bytes.push_back(CHAR_MINUS);
         default: begin
         end
      endcase
      n = ($urandom_range(3) == 0) ? $urandom_range(11) : $urandom_range(1, 4);
      repeat (n) line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
   endtask

   task automatic add_random_word();
      case ($urandom_range(5))
         0: begin
            line_bytes.push_back(CHAR_UPPER_G);
            if ($urandom_range(2) != 0)
               push_text($sformatf("%0d", known_g[$urandom_range(4)]));
            else if ($urandom_range(1) != 0)
               push_text($sformatf("%0d", $urandom_range(999)));
         end
         1: begin
            line_bytes.push_back(CHAR_UPPER_M);
            if ($urandom_range(1) != 0) push_text($sformatf("%0d", CMD_M30));
            else push_text($sformatf("%0d", $urandom_range(99)));
         end
         2: begin
            line_bytes.push_back(CHAR_UPPER_X);
            add_digits();
         end
         3: begin
            line_bytes.push_back(CHAR_UPPER_Y);
            add_digits();
         end
         4: begin
            line_bytes.push_back(CHAR_UPPER_Z);
            add_digits();
         end
         default: begin
            line_bytes.push_back(CHAR_UPPER_F);
            add_digits();
         end
      endcase
   endtask

   task automatic build_random_line();
      int                kind;
      int                words;
      int                spot;
      logic [CHAR_W-1:0] junk;
      line_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 24)) line_bytes.push_back(8'($urandom_range(255)));
      end else begin
         if (kind < 14) repeat ($urandom_range(100, 130)) line_bytes.push_back(CHAR_SPACE);
         words = $urandom_range(5);
         for (int w = 0; w < words; w++) begin
            if (w > 0 || $urandom_range(3) == 0)
               repeat ($urandom_range(1, 2))
                  line_bytes.push_back($urandom_range(3) == 0 ? CHAR_TAB : CHAR_SPACE);
            add_random_word();
         end
         if (kind >= 80 && line_bytes.size() > 0) begin
            case ($urandom_range(2))
               0:       junk = CHAR_NUL;
               1:       junk = 8'($urandom_range(97, 122));
               default: junk = 8'($urandom_range(255));
            endcase
            spot = $urandom_range(line_bytes.size() - 1);
            line_bytes.insert(spot, junk);
         end
      end
   endtask

   task automatic random_lines(input int budget);
      int start;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         build_random_line();
         send_line();
      end
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 8;
      recv_idle_pct = 49;

      send_text("");
      send_text("G0 X10 Y-20 Z+30 F1500");
      send_text("G1");
      send_text("G21");
      send_text("G28");
      send_text("G90");
      send_text("G7");
      send_text("G");
      send_text("M30");
      send_text("G1 M5 F-1");
      send_text("G90 G1 X1 X2");
      send_text("X2147483647 Y-2147483648 Z99999999999 F70000");
      send_text("Y-99999999999 X+-5 Z5a7");
      send_text("x5 g1 A7 Q Z3");
      send_text("G1\tX3\tY4");
      push_text("X12");
      line_bytes.push_back(CHAR_NUL);
      push_text(" Y5");
      send_line();
      line_bytes.push_back(8'hFF);
      push_text(" G28 ");
      line_bytes.push_back(8'h80);
      push_text(" F65535");
      send_line();
      repeat (120) line_bytes.push_back(CHAR_SPACE);
      push_text("G1 X1234567 Y9");
      send_line();

      random_lines(PHASE_CHARS);
      drain_lines();

      write_reg(CSR_SPU_X, '0);
      write_reg(CSR_SPU_Y, '1);
      write_reg(CSR_SPU_Z, 16'($urandom_range(1, 1000)));
      write_reg(CSR_SPARE, 16'($urandom));
      send_idle_pct = 49;
      recv_idle_pct = 8;
      send_text("X2147483647 Y-2147483648 Z-3");
      random_lines(PHASE_CHARS);
      drain_lines();

      write_reg(CSR_SPU_X, '1);
      write_reg(CSR_SPU_Y, '0);
      write_reg(CSR_SPU_Z, 16'($urandom));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      long_stall_req <= 1'b1;
      send_text("X-40000 Y7 Z-1");
      send_text("G1");
      send_text("M30");
      random_lines(PHASE_CHARS);
      drain_lines();

      if (error_count == 0 && pending_count == 0)
         $display("gcode_line_to_step_command test passed");
      else
         $display("gcode_line_to_step_command test failed");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("gcode_line_to_step_command test failed");
      $finish;
   end

endmodule
